/* rtl/core/tab_pkg.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tab_pkg
// Shared types, register map and arithmetic helpers for the tinted alpha
// blend pixel core.
// -----------------------------------------------------------------------------
package tab_pkg;

	// source texel encodings
	localparam logic [1:0] SRC_A8       = 2'd0;
	localparam logic [1:0] SRC_RGB565   = 2'd1;
	localparam logic [1:0] SRC_RGB888   = 2'd2;
	localparam logic [1:0] SRC_RGBA8888 = 2'd3;

	// destination encodings
	localparam logic TGT_RGB565 = 1'b0;
	localparam logic TGT_RGB888 = 1'b1;

	// register indexes (byte address = 4 * index)
	localparam logic [2:0] REG_SOURCE_FORMAT   = 3'd0;
	localparam logic [2:0] REG_TARGET_FORMAT   = 3'd1;
	localparam logic [2:0] REG_TINT_RED        = 3'd2;
	localparam logic [2:0] REG_TINT_GREEN      = 3'd3;
	localparam logic [2:0] REG_TINT_BLUE       = 3'd4;
	localparam logic [2:0] REG_TINT_ALPHA      = 3'd5;
	localparam logic [2:0] REG_SURFACE_OPACITY = 3'd6;

	localparam int ADDR_W = 5;

	typedef struct packed {
		logic [31:0] source_texel;
		logic [23:0] dest_pixel;
	} pix_in_t;

	typedef struct packed {
		logic        write_enable;
		logic [23:0] new_pixel;
	} pix_out_t;

	typedef struct packed {
		logic [1:0] source_format;
		logic       dest_format;
		logic [7:0] tint_red;
		logic [7:0] tint_green;
		logic [7:0] tint_blue;
		logic [7:0] tint_alpha;
		logic [7:0] surface_opacity;
	} cfg_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	// work item passed from front to back: tinted source and decoded destination
	typedef struct packed {
		rgb_t       src;
		logic [7:0] alpha;
		rgb_t       dst;
	} blend_job_t;

	// floor(v / 255) for v below 65280
	function automatic logic [7:0] div255(input logic [15:0] v);
		logic [16:0] t;
		t = {1'b0, v} + 17'd1 + {9'd0, v[15:8]};
		return t[15:8];
	endfunction

	// rounded normalized multiply (x * y + 127) / 255
	function automatic logic [7:0] norm_mul(input logic [7:0] x, input logic [7:0] y);
		logic [15:0] p;
		p = x * y + 16'd127;
		return div255(p);
	endfunction

	function automatic rgb_t unpack565(input logic [15:0] w);
		rgb_t c;
		c.r = {w[15:11], w[15:13]};
		c.g = {w[10:5], w[10:9]};
		c.b = {w[4:0], w[4:2]};
		return c;
	endfunction

	function automatic rgb_t unpack888(input logic [23:0] w);
		rgb_t c;
		c.r = w[7:0];
		c.g = w[15:8];
		c.b = w[23:16];
		return c;
	endfunction

	function automatic logic [23:0] pack_target(input logic fmt, input rgb_t c);
		logic [23:0] w;
		if (fmt == TGT_RGB565) begin
			w = {8'd0, c.r[7:3], c.g[7:2], c.b[7:3]};
		end else begin
			w = {c.b, c.g, c.r};
		end
		return w;
	endfunction

endpackage

/* rtl/core/tab_front.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tab_front
// Accepts pixels, decodes the texel by source format, applies tint and
// opacity, decodes the destination pixel and pushes a blend job.
// -----------------------------------------------------------------------------
module tab_front (
	input  logic              clk,
	input  logic              arst_n,
	input  tab_pkg::cfg_t     cfg,
	input  logic              src_valid,
	output logic              src_stall,
	input  tab_pkg::pix_in_t  src_data,
	output logic              push,
	output tab_pkg::blend_job_t push_data,
	input  logic              full
);
	import tab_pkg::*;

	logic       valid_s1, valid_s2;
	logic       adv_s1, adv_s2;
	rgb_t       src_s1, dst_s1;
	logic [7:0] alpha_s1;
	logic [7:0] texel_a_s1;
	blend_job_t job_s2;

	rgb_t       texel_rgb;
	rgb_t       src_rgb;
	logic [7:0] a1_x;
	logic [7:0] a2_x, a2_y, alpha_next;

	assign adv_s2    = !valid_s2 || !full;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign src_stall = !adv_s1;

	always_comb begin
		if (cfg.source_format == SRC_RGB565) begin
			texel_rgb = unpack565(src_data.source_texel[15:0]);
		end else begin
			texel_rgb = unpack888(src_data.source_texel[23:0]);
		end
		if (cfg.source_format == SRC_A8) begin
			src_rgb = '{r: cfg.tint_red, g: cfg.tint_green, b: cfg.tint_blue};
			a1_x    = src_data.source_texel[7:0];
		end else begin
			src_rgb.r = norm_mul(texel_rgb.r, cfg.tint_red);
			src_rgb.g = norm_mul(texel_rgb.g, cfg.tint_green);
			src_rgb.b = norm_mul(texel_rgb.b, cfg.tint_blue);
			a1_x      = cfg.surface_opacity;
		end
	end

	// second alpha product: A8 applies opacity, RGBA8888 applies texel alpha
	always_comb begin
		if (cfg.source_format == SRC_A8) begin
			a2_x = alpha_s1;
			a2_y = cfg.surface_opacity;
		end else begin
			a2_x = texel_a_s1;
			a2_y = alpha_s1;
		end
		if (cfg.source_format == SRC_A8 || cfg.source_format == SRC_RGBA8888) begin
			alpha_next = norm_mul(a2_x, a2_y);
		end else begin
			alpha_next = alpha_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= src_valid;
			if (adv_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			src_s1     <= src_rgb;
			alpha_s1   <= norm_mul(a1_x, cfg.tint_alpha);
			texel_a_s1 <= src_data.source_texel[31:24];
			if (cfg.dest_format == TGT_RGB565) begin
				dst_s1 <= unpack565(src_data.dest_pixel[15:0]);
			end else begin
				dst_s1 <= unpack888(src_data.dest_pixel);
			end
		end
		if (adv_s2) begin
			job_s2.src   <= src_s1;
			job_s2.alpha <= alpha_next;
			job_s2.dst   <= dst_s1;
		end
	end

	assign push      = valid_s2 && !full;
	assign push_data = job_s2;

endmodule

/* rtl/core/tab_queue.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tab_queue
// Small FIFO of blend jobs between the front and back halves.
// -----------------------------------------------------------------------------
module tab_queue #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  tab_pkg::blend_job_t push_data,
	output logic                full,
	input  logic                pop,
	output tab_pkg::blend_job_t pop_data,
	output logic                empty
);
	import tab_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	blend_job_t       mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == FULL_CNT);
	assign empty    = (count_q == '0);
	assign pop_data = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			if (pop)  rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

/* rtl/core/tab_back.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tab_back
// Blends queued source colour over the destination and encodes the result
// into the output register.
// -----------------------------------------------------------------------------
module tab_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                dest_format,
	input  logic                empty,
	output logic                pop,
	input  tab_pkg::blend_job_t pop_data,
	output logic                res_valid,
	input  logic                res_stall,
	output tab_pkg::pix_out_t   res_data
);
	import tab_pkg::*;

	logic        valid_b1, adv_b1, adv_out;
	logic [15:0] sum_r_b1, sum_g_b1, sum_b_b1;
	logic        skip_b1;
	logic [7:0]  inv_a;
	rgb_t        mixed;
	logic        res_valid_q;
	pix_out_t    res_q;

	assign adv_out = !res_valid_q || !res_stall;
	assign adv_b1  = !valid_b1 || adv_out;
	assign pop     = !empty && adv_b1;
	assign inv_a   = 8'd255 - pop_data.alpha;

	// alpha 255 reduces to the source colour, so one formula covers both
	always_ff @(posedge clk) begin
		if (adv_b1) begin
			sum_r_b1 <= pop_data.src.r * pop_data.alpha + pop_data.dst.r * inv_a + 16'd127;
			sum_g_b1 <= pop_data.src.g * pop_data.alpha + pop_data.dst.g * inv_a + 16'd127;
			sum_b_b1 <= pop_data.src.b * pop_data.alpha + pop_data.dst.b * inv_a + 16'd127;
			skip_b1  <= (pop_data.alpha == 8'd0);
		end
		if (adv_out) begin
			res_q.write_enable <= !skip_b1;
			res_q.new_pixel    <= skip_b1 ? 24'd0 : pack_target(dest_format, mixed);
		end
	end

	always_comb begin
		mixed.r = div255(sum_r_b1);
		mixed.g = div255(sum_g_b1);
		mixed.b = div255(sum_b_b1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_b1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (adv_b1)  valid_b1    <= !empty;
			if (adv_out) res_valid_q <= valid_b1;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule

/* rtl/core/tinted_alpha_blend_pixel_core.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tinted_alpha_blend_pixel_core
// Tinted source-over blend of one pixel per transfer, A8/RGB565/RGB888/
// RGBA8888 sources onto RGB565/RGB888 destinations.
//
//   channel | handshake                 | payload
//   --------+---------------------------+-------------------------------
//   src     | src_valid / src_stall     | source_texel, dest_pixel
//   res     | res_valid / res_stall     | write_enable, new_pixel
//   cfg     | APB psel/penable/pwrite   | 7 registers at 4*index
//
// One pixel per clock sustained while res is not stalled; res_valid rises once
// the src transfer has passed front s1/s2, queue, blend stage, output register.
// The job queue lets the front keep accepting while res is stalled, until
// the queue and front stages fill; src_stall then rises from registered state.
// Reset clears handshake state and loads register defaults.
// -----------------------------------------------------------------------------
module tinted_alpha_blend_pixel_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            src_valid,
	output logic                            src_stall,
	input  tab_pkg::pix_in_t                src_data,
	output logic                            res_valid,
	input  logic                            res_stall,
	output tab_pkg::pix_out_t               res_data,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [tab_pkg::ADDR_W-1:0]      paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);
	import tab_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	logic       push, full, pop, empty;
	blend_job_t push_data, pop_data;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.source_format   <= SRC_A8;
			cfg_q.dest_format     <= TGT_RGB565;
			cfg_q.tint_red        <= 8'd255;
			cfg_q.tint_green      <= 8'd255;
			cfg_q.tint_blue       <= 8'd255;
			cfg_q.tint_alpha      <= 8'd255;
			cfg_q.surface_opacity <= 8'd255;
		end else if (wr_en) begin
			case (reg_idx)
				REG_SOURCE_FORMAT:   cfg_q.source_format   <= pwdata[1:0];
				REG_TARGET_FORMAT:   cfg_q.dest_format     <= pwdata[0];
				REG_TINT_RED:        cfg_q.tint_red        <= pwdata[7:0];
				REG_TINT_GREEN:      cfg_q.tint_green      <= pwdata[7:0];
				REG_TINT_BLUE:       cfg_q.tint_blue       <= pwdata[7:0];
				REG_TINT_ALPHA:      cfg_q.tint_alpha      <= pwdata[7:0];
				REG_SURFACE_OPACITY: cfg_q.surface_opacity <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SOURCE_FORMAT:   prdata = {30'd0, cfg_q.source_format};
			REG_TARGET_FORMAT:   prdata = {31'd0, cfg_q.dest_format};
			REG_TINT_RED:        prdata = {24'd0, cfg_q.tint_red};
			REG_TINT_GREEN:      prdata = {24'd0, cfg_q.tint_green};
			REG_TINT_BLUE:       prdata = {24'd0, cfg_q.tint_blue};
			REG_TINT_ALPHA:      prdata = {24'd0, cfg_q.tint_alpha};
			REG_SURFACE_OPACITY: prdata = {24'd0, cfg_q.surface_opacity};
			default:             prdata = 32'd0;
		endcase
	end

	tab_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_data  (src_data),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	tab_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	tab_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.dest_format (cfg_q.dest_format),
		.empty       (empty),
		.pop         (pop),
		.pop_data    (pop_data),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res_data    (res_data)
	);

endmodule
